// File: rtl/pkf_pkg.sv
// ----------------------------------------------------------------------------
// pkf_pkg
// Types, codes and saturating helpers shared by the pitch Kalman filter.
// ----------------------------------------------------------------------------
package pkf_pkg;

    typedef enum logic [1:0] {
        MODE_INIT = 2'd0,
        MODE_MEAS = 2'd1,
        MODE_TIME = 2'd2,
        MODE_HOLD = 2'd3
    } pkf_mode_t;

    typedef enum logic [1:0] {
        REG_MEAS_NOISE = 2'd0,
        REG_PROC_NOISE = 2'd1,
        REG_GAIN_ANGLE = 2'd2,
        REG_GAIN_RATE  = 2'd3
    } pkf_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DONE
    } pkf_state_t;

    // micro steps: M_* measurement update, T_* time update
    typedef enum logic [4:0] {
        M_PREP, M_K0, M_K1, M_XCOR, M_RCOR, M_AB, M_T, M_H0, M_H1,
        M_AP, M_APA, M_HK0, M_TB, M_BP, M_HK1, M_TA, M_HK0B,
        T_B, T_X, T_R, T_P, T_S0, T_S1, T_AA, T_AR, T_RR
    } pkf_step_t;

    typedef enum logic [1:0] {
        AR_IDLE,
        AR_MUL,
        AR_DIV,
        AR_DONE
    } pkf_arith_state_t;

    typedef struct packed {
        logic start;
        logic div;
        logic state_frac;
    } pkf_req_t;

    localparam logic signed [63:0] W_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] W_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [63:0]        PI60  = 64'h3243_F6A8_885A_308D;

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63])
        begin
            s = W_MAX;
        end
        else if (a[63] && b[63] && !s[63])
        begin
            s = W_MIN;
        end
        return s;
    endfunction

    function automatic logic signed [63:0] neg_sat(input logic signed [63:0] v);
        return (v == W_MIN) ? W_MAX : -v;
    endfunction

endpackage

// File: rtl/pkf_if.sv
// ----------------------------------------------------------------------------
// pkf_if
// Valid/ready channels of the pitch Kalman filter: input, result, config.
// ----------------------------------------------------------------------------
interface pkf_in_if #(parameter int STATE_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic signed [STATE_WIDTH-1:0] measured_pitch;
    logic signed [STATE_WIDTH-1:0] pitch_torque;

    modport source (output valid, mode, measured_pitch, pitch_torque, input ready);
    modport sink   (input valid, mode, measured_pitch, pitch_torque, output ready);
endinterface

interface pkf_out_if #(parameter int STATE_WIDTH = 32, parameter int COV_WIDTH = 48);
    logic                          valid;
    logic                          ready;
    logic signed [STATE_WIDTH-1:0] angle_out;
    logic signed [STATE_WIDTH-1:0] rate_out;
    logic signed [COV_WIDTH-1:0]   var_angle;
    logic signed [COV_WIDTH-1:0]   cov_cross;
    logic signed [COV_WIDTH-1:0]   var_rate;

    modport source (output valid, angle_out, rate_out, var_angle, cov_cross, var_rate,
                    input ready);
    modport sink   (input valid, angle_out, rate_out, var_angle, cov_cross, var_rate,
                    output ready);
endinterface

interface pkf_cfg_if #(parameter int DATA_WIDTH = 64);
    logic                  valid;
    logic                  ready;
    logic [1:0]            index;
    logic [DATA_WIDTH-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/pkf_arith.sv
// ----------------------------------------------------------------------------
// pkf_arith
// Shared bit-serial unit: rounded scaled multiply and scaled divide, 64-bit.
// ----------------------------------------------------------------------------
module pkf_arith #(
    parameter int SFRAC = 28,
    parameter int CFRAC = 44
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pkf_pkg::pkf_req_t  req,
    input  logic signed [63:0] op_a,
    input  logic signed [63:0] op_b,
    output logic               done,
    output logic signed [63:0] res
);

    localparam int DIV_STEPS = 64 + CFRAC;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    pkf_pkg::pkf_arith_state_t state_reg, state_next;

    logic [127:0]     acc_reg;
    logic [63:0]      mcand_reg;
    logic [63:0]      mplier_reg;
    logic [63:0]      rem_reg;
    logic [63:0]      q_reg;
    logic             ovf_reg;
    logic             neg_reg;
    logic             frac_reg;
    logic             div_reg;
    logic             zero_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [63:0]  mag_a, mag_b;
    logic [64:0]  psum;
    logic [64:0]  rem2;
    logic         ge;
    logic [127:0] sh_p;
    logic         rnd;
    logic [64:0]  vr;
    logic         over;
    logic [63:0]  mag_r;

    assign mag_a = op_a[63] ? 64'(-op_a) : 64'(op_a);
    assign mag_b = op_b[63] ? 64'(-op_b) : 64'(op_b);
    assign psum  = {1'b0, acc_reg[127:64]} + (mplier_reg[0] ? {1'b0, mcand_reg} : 65'd0);
    assign rem2  = {rem_reg, mplier_reg[63]};
    assign ge    = rem2 >= {1'b0, mcand_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pkf_pkg::AR_IDLE:
            begin
                if (req.start)
                begin
                    if (!req.div)
                    begin
                        state_next = pkf_pkg::AR_MUL;
                    end
                    else if (op_b == 64'sd0)
                    begin
                        state_next = pkf_pkg::AR_DONE;
                    end
                    else
                    begin
                        state_next = pkf_pkg::AR_DIV;
                    end
                end
            end
            pkf_pkg::AR_MUL:
            begin
                if (cnt_reg == CNT_W'(63))
                begin
                    state_next = pkf_pkg::AR_DONE;
                end
            end
            pkf_pkg::AR_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = pkf_pkg::AR_DONE;
                end
            end
            pkf_pkg::AR_DONE:
            begin
                state_next = pkf_pkg::AR_IDLE;
            end
            default:
            begin
                state_next = pkf_pkg::AR_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        done  = (state_reg == pkf_pkg::AR_DONE);
        sh_p  = frac_reg ? (acc_reg >> SFRAC) : (acc_reg >> CFRAC);
        rnd   = frac_reg ? acc_reg[SFRAC-1] : acc_reg[CFRAC-1];
        vr    = {1'b0, sh_p[63:0]} + 65'(rnd);
        if (div_reg)
        begin
            over  = ovf_reg | q_reg[63];
            mag_r = q_reg;
        end
        else
        begin
            over  = (|sh_p[127:64]) | vr[64] | vr[63];
            mag_r = vr[63:0];
        end
        if (zero_reg)
        begin
            res = 64'sd0;
        end
        else if (over)
        begin
            res = neg_reg ? pkf_pkg::W_MIN : pkf_pkg::W_MAX;
        end
        else
        begin
            res = neg_reg ? -signed'(mag_r) : signed'(mag_r);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pkf_pkg::AR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            pkf_pkg::AR_IDLE:
            begin
                if (req.start)
                begin
                    neg_reg    <= op_a[63] ^ op_b[63];
                    div_reg    <= req.div;
                    frac_reg   <= req.state_frac;
                    zero_reg   <= req.div && (op_b == 64'sd0);
                    mcand_reg  <= req.div ? mag_b : mag_a;
                    mplier_reg <= req.div ? mag_a : mag_b;
                    acc_reg    <= '0;
                    rem_reg    <= '0;
                    q_reg      <= '0;
                    ovf_reg    <= 1'b0;
                    cnt_reg    <= '0;
                end
            end
            pkf_pkg::AR_MUL:
            begin
                acc_reg    <= {psum, acc_reg[63:1]};
                mplier_reg <= {1'b0, mplier_reg[63:1]};
                cnt_reg    <= cnt_reg + 1'b1;
            end
            pkf_pkg::AR_DIV:
            begin
                rem_reg    <= ge ? 64'(rem2 - {1'b0, mcand_reg}) : rem2[63:0];
                q_reg      <= {q_reg[62:0], ge};
                ovf_reg    <= ovf_reg | q_reg[63];
                mplier_reg <= {mplier_reg[62:0], 1'b0};
                cnt_reg    <= cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: rtl/pitch_kalman_filter.sv
// ----------------------------------------------------------------------------
// pitch_kalman_filter
// Two-state pitch estimator (angle, rate, 2x2 covariance) in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    : register writes (0 meas noise R, 1 process noise Q, 2/3 torque
//            gains). Always ready; write only while the filter is idle.
//   sample : one command per transfer; mode 0 init, 1 measurement update,
//            2 time update, 3 report state unchanged.
//   result : one transfer per command with the state after it.
// Steps: modes 0 and 3 skip the calculation and go straight to the done
//   state. A measurement update is two serial divides plus 13 serial
//   multiplies; a time update is 7 multiplies. Both run on the single
//   shared bit-serial multiply/divide unit.
// One command is processed at a time; sample.ready is high in idle. The
//   result register decouples the outputs: the next command may start while
//   a result waits, and a finished command waits until that register frees.
// Reset clears the state, the configuration registers and the result valid.
// ----------------------------------------------------------------------------
module pitch_kalman_filter #(
    parameter int STATE_WIDTH = 32,
    parameter int COV_WIDTH   = 48
) (
    input  logic      clk,
    input  logic      rst_n,
    pkf_cfg_if.sink   cfg,
    pkf_in_if.sink    sample,
    pkf_out_if.source result
);

    localparam int SFRAC = STATE_WIDTH - 4;
    localparam int CFRAC = COV_WIDTH - 4;

    localparam logic signed [63:0] PI_S    =
        signed'(64'((pkf_pkg::PI60 + (64'd1 << (59 - SFRAC))) >> (60 - SFRAC)));
    localparam logic signed [63:0] TWOPI_S =
        signed'(64'((pkf_pkg::PI60 + (64'd1 << (58 - SFRAC))) >> (59 - SFRAC)));
    localparam logic signed [63:0] S_MAX   = (64'sd1 <<< (STATE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] S_MIN   = -S_MAX - 64'sd1;
    localparam logic signed [63:0] C_MAX   = (64'sd1 <<< (COV_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] C_MIN   = -C_MAX - 64'sd1;
    localparam logic signed [63:0] ONE_C   = 64'sd1 <<< CFRAC;
    localparam logic [63:0]        DEG     = pkf_pkg::PI60 / 64'd180;
    localparam logic [63:0]        DEG10   = DEG / 64'd10;

    // elaboration only: rounded square for the initial variances
    function automatic logic [63:0] init_var(input logic [63:0] v, input int sh);
        logic [127:0] p;
        p = 128'(v) * 128'(v);
        p = p + (128'd1 << (sh - 1));
        return 64'(p >> sh);
    endfunction

    localparam logic [63:0] INIT_AA = init_var(DEG << 1, 120 - CFRAC);
    localparam logic [63:0] INIT_RR = init_var(DEG10, 120 - CFRAC);

    function automatic logic signed [STATE_WIDTH-1:0] sat_s(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = (x > S_MAX) ? S_MAX : ((x < S_MIN) ? S_MIN : x);
        return y[STATE_WIDTH-1:0];
    endfunction

    function automatic logic signed [COV_WIDTH-1:0] sat_c(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = (x > C_MAX) ? C_MAX : ((x < C_MIN) ? C_MIN : x);
        return y[COV_WIDTH-1:0];
    endfunction

    function automatic logic signed [63:0] wrap(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = (x > PI_S) ? x - TWOPI_S : x;
        y = (y < -PI_S) ? y + TWOPI_S : y;
        return y;
    endfunction

    // configuration
    logic [COV_WIDTH-1:0]          r_reg, q_reg;
    logic signed [STATE_WIDTH-1:0] ga_reg, gr_reg;

    // filter state
    logic signed [STATE_WIDTH-1:0] ang_reg, rat_reg;
    logic signed [COV_WIDTH-1:0]   caa_reg, car_reg, crr_reg;

    // command and work registers
    pkf_pkg::pkf_state_t           state_reg, state_next;
    pkf_pkg::pkf_step_t            step_reg, step_next;
    logic                          run_reg;
    logic signed [STATE_WIDTH-1:0] arg_reg;
    logic signed [63:0]            xw_reg, err_reg, den_reg, k0_reg, k1_reg;
    logic signed [63:0]            ca_reg, cb_reg, tt_reg, h0_reg, h1_reg, p1_reg;

    // result register
    logic                          out_valid_reg;
    logic signed [STATE_WIDTH-1:0] out_ang_reg, out_rat_reg;
    logic signed [COV_WIDTH-1:0]   out_aa_reg, out_ar_reg, out_rr_reg;

    // wide views
    logic signed [63:0] ang_w, rat_w, caa_w, car_w, crr_w, z_w, r_w, q_w, ga_w, gr_w;
    logic signed [63:0] x1, x2;

    // sequencer / arithmetic unit
    pkf_pkg::pkf_req_t  req;
    logic signed [63:0] op_a, op_b, ar_res;
    logic               ar_done;
    logic               alu_step, last_step, step_fin, load_out;
    logic               in_xfer, out_xfer;

    assign ang_w = 64'(ang_reg);
    assign rat_w = 64'(rat_reg);
    assign caa_w = 64'(caa_reg);
    assign car_w = 64'(car_reg);
    assign crr_w = 64'(crr_reg);
    assign z_w   = 64'(arg_reg);
    assign ga_w  = 64'(ga_reg);
    assign gr_w  = 64'(gr_reg);
    // noise values above the 64-bit signed range clip (only at full width)
    assign r_w   = (COV_WIDTH == 64 && r_reg[COV_WIDTH-1]) ? pkf_pkg::W_MAX
                                                          : signed'(64'(r_reg));
    assign q_w   = (COV_WIDTH == 64 && q_reg[COV_WIDTH-1]) ? pkf_pkg::W_MAX
                                                          : signed'(64'(q_reg));

    // unwrap the estimate toward the measurement by at most one turn each way
    assign x1 = (z_w - ang_w > PI_S) ? ang_w + TWOPI_S : ang_w;
    assign x2 = (z_w - x1 < -PI_S) ? x1 - TWOPI_S : x1;

    assign in_xfer  = sample.valid && sample.ready;
    assign out_xfer = result.valid && result.ready;

    assign cfg.ready        = 1'b1;
    assign result.valid     = out_valid_reg;
    assign result.angle_out = out_ang_reg;
    assign result.rate_out  = out_rat_reg;
    assign result.var_angle = out_aa_reg;
    assign result.cov_cross = out_ar_reg;
    assign result.var_rate  = out_rr_reg;

    pkf_arith #(
        .SFRAC(SFRAC),
        .CFRAC(CFRAC)
    ) u_arith (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .op_a (op_a),
        .op_b (op_b),
        .done (ar_done),
        .res  (ar_res)
    );

    // step classification and operand selection
    always_comb
    begin
        alu_step  = 1'b0;
        last_step = 1'b0;
        op_a      = k0_reg;
        op_b      = err_reg;
        req.div   = 1'b0;
        req.state_frac = 1'b0;
        step_next = step_reg;
        case (step_reg)
            pkf_pkg::M_PREP: begin alu_step = 1'b1; step_next = pkf_pkg::M_K0; end
            pkf_pkg::M_K0:
            begin
                op_a = caa_w; op_b = den_reg; req.div = 1'b1; step_next = pkf_pkg::M_K1;
            end
            pkf_pkg::M_K1:
            begin
                op_a = car_w; op_b = den_reg; req.div = 1'b1; step_next = pkf_pkg::M_XCOR;
            end
            pkf_pkg::M_XCOR: begin op_a = k0_reg; op_b = err_reg; step_next = pkf_pkg::M_RCOR; end
            pkf_pkg::M_RCOR: begin op_a = k1_reg; op_b = err_reg; step_next = pkf_pkg::M_AB; end
            pkf_pkg::M_AB:   begin alu_step = 1'b1; step_next = pkf_pkg::M_T; end
            pkf_pkg::M_T:    begin op_a = cb_reg; op_b = caa_w; step_next = pkf_pkg::M_H0; end
            pkf_pkg::M_H0:   begin op_a = k0_reg; op_b = r_w; step_next = pkf_pkg::M_H1; end
            pkf_pkg::M_H1:   begin op_a = k1_reg; op_b = r_w; step_next = pkf_pkg::M_AP; end
            pkf_pkg::M_AP:   begin op_a = ca_reg; op_b = caa_w; step_next = pkf_pkg::M_APA; end
            pkf_pkg::M_APA:  begin op_a = p1_reg; op_b = ca_reg; step_next = pkf_pkg::M_HK0; end
            pkf_pkg::M_HK0:  begin op_a = h0_reg; op_b = k0_reg; step_next = pkf_pkg::M_TB; end
            pkf_pkg::M_TB:   begin op_a = tt_reg; op_b = cb_reg; step_next = pkf_pkg::M_BP; end
            pkf_pkg::M_BP:   begin op_a = cb_reg; op_b = car_w; step_next = pkf_pkg::M_HK1; end
            pkf_pkg::M_HK1:  begin op_a = h1_reg; op_b = k1_reg; step_next = pkf_pkg::M_TA; end
            pkf_pkg::M_TA:   begin op_a = tt_reg; op_b = ca_reg; step_next = pkf_pkg::M_HK0B; end
            pkf_pkg::M_HK0B: begin op_a = h1_reg; op_b = k0_reg; last_step = 1'b1; end
            pkf_pkg::T_B:    begin alu_step = 1'b1; step_next = pkf_pkg::T_X; end
            pkf_pkg::T_X:
            begin
                op_a = k0_reg; op_b = z_w; req.state_frac = 1'b1; step_next = pkf_pkg::T_R;
            end
            pkf_pkg::T_R:
            begin
                op_a = k1_reg; op_b = z_w; req.state_frac = 1'b1; step_next = pkf_pkg::T_P;
            end
            pkf_pkg::T_P:    begin alu_step = 1'b1; step_next = pkf_pkg::T_S0; end
            pkf_pkg::T_S0:
            begin
                op_a = k0_reg; op_b = q_w; req.state_frac = 1'b1; step_next = pkf_pkg::T_S1;
            end
            pkf_pkg::T_S1:
            begin
                op_a = k1_reg; op_b = q_w; req.state_frac = 1'b1; step_next = pkf_pkg::T_AA;
            end
            pkf_pkg::T_AA:
            begin
                op_a = h0_reg; op_b = k0_reg; req.state_frac = 1'b1; step_next = pkf_pkg::T_AR;
            end
            pkf_pkg::T_AR:
            begin
                op_a = h1_reg; op_b = k0_reg; req.state_frac = 1'b1; step_next = pkf_pkg::T_RR;
            end
            pkf_pkg::T_RR:
            begin
                op_a = h1_reg; op_b = k1_reg; req.state_frac = 1'b1; last_step = 1'b1;
            end
            default:
            begin
                last_step = 1'b1;
            end
        endcase
        // launch an operation once per arithmetic step
        req.start = (state_reg == pkf_pkg::ST_CALC) && !alu_step && !run_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pkf_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (sample.mode == pkf_pkg::MODE_MEAS || sample.mode == pkf_pkg::MODE_TIME)
                    begin
                        state_next = pkf_pkg::ST_CALC;
                    end
                    else
                    begin
                        state_next = pkf_pkg::ST_DONE;
                    end
                end
            end
            pkf_pkg::ST_CALC:
            begin
                if (step_fin && last_step)
                begin
                    state_next = pkf_pkg::ST_DONE;
                end
            end
            pkf_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = pkf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pkf_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        sample.ready = (state_reg == pkf_pkg::ST_IDLE);
        step_fin     = (state_reg == pkf_pkg::ST_CALC) && (alu_step || ar_done);
        load_out     = (state_reg == pkf_pkg::ST_DONE) && (!out_valid_reg || result.ready);
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pkf_pkg::ST_IDLE;
            step_reg      <= pkf_pkg::M_PREP;
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            r_reg         <= '0;
            q_reg         <= '0;
            ga_reg        <= '0;
            gr_reg        <= '0;
            ang_reg       <= '0;
            rat_reg       <= '0;
            caa_reg       <= '0;
            car_reg       <= '0;
            crr_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    pkf_pkg::REG_MEAS_NOISE: r_reg  <= cfg.data[COV_WIDTH-1:0];
                    pkf_pkg::REG_PROC_NOISE: q_reg  <= cfg.data[COV_WIDTH-1:0];
                    pkf_pkg::REG_GAIN_ANGLE: ga_reg <= cfg.data[STATE_WIDTH-1:0];
                    pkf_pkg::REG_GAIN_RATE:  gr_reg <= cfg.data[STATE_WIDTH-1:0];
                    default: begin end
                endcase
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end

            if (req.start)
            begin
                run_reg <= 1'b1;
            end
            else if (ar_done)
            begin
                run_reg <= 1'b0;
            end

            if (in_xfer)
            begin
                step_reg <= (sample.mode == pkf_pkg::MODE_TIME) ? pkf_pkg::T_B : pkf_pkg::M_PREP;
                if (sample.mode == pkf_pkg::MODE_INIT)
                begin
                    ang_reg <= sample.measured_pitch;
                    rat_reg <= '0;
                    caa_reg <= INIT_AA[COV_WIDTH-1:0];
                    car_reg <= '0;
                    crr_reg <= INIT_RR[COV_WIDTH-1:0];
                end
            end
            else if (step_fin)
            begin
                step_reg <= step_next;
                case (step_reg)
                    pkf_pkg::M_XCOR:
                        ang_reg <= sat_s(wrap(pkf_pkg::sadd(xw_reg, ar_res)));
                    pkf_pkg::M_RCOR:
                        rat_reg <= sat_s(pkf_pkg::sadd(rat_w, ar_res));
                    pkf_pkg::M_HK0:
                        caa_reg <= sat_c(pkf_pkg::sadd(p1_reg, ar_res));
                    pkf_pkg::M_HK1:
                        crr_reg <= sat_c(pkf_pkg::sadd(p1_reg, ar_res));
                    pkf_pkg::M_HK0B:
                        car_reg <= sat_c(pkf_pkg::sadd(p1_reg, ar_res));
                    pkf_pkg::T_R:
                    begin
                        rat_reg <= sat_s(pkf_pkg::sadd(rat_w, ar_res));
                        ang_reg <= sat_s(wrap(xw_reg));
                    end
                    pkf_pkg::T_AA:
                        caa_reg <= sat_c(pkf_pkg::sadd(den_reg, ar_res));
                    pkf_pkg::T_AR:
                        car_reg <= sat_c(pkf_pkg::sadd(tt_reg, ar_res));
                    pkf_pkg::T_RR:
                        crr_reg <= sat_c(pkf_pkg::sadd(crr_w, ar_res));
                    default: begin end
                endcase
            end
        end
    end

    // work registers and result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            arg_reg <= (sample.mode == pkf_pkg::MODE_TIME) ? sample.pitch_torque
                                                           : sample.measured_pitch;
        end

        if (load_out)
        begin
            out_ang_reg <= ang_reg;
            out_rat_reg <= rat_reg;
            out_aa_reg  <= caa_reg;
            out_ar_reg  <= car_reg;
            out_rr_reg  <= crr_reg;
        end

        if (step_fin)
        begin
            case (step_reg)
                pkf_pkg::M_PREP:
                begin
                    xw_reg  <= x2;
                    err_reg <= z_w - x2;
                    den_reg <= pkf_pkg::sadd(caa_w, r_w);
                end
                pkf_pkg::M_K0:   k0_reg <= ar_res;
                pkf_pkg::M_K1:   k1_reg <= ar_res;
                pkf_pkg::M_XCOR: xw_reg <= pkf_pkg::sadd(xw_reg, ar_res);
                pkf_pkg::M_AB:
                begin
                    ca_reg <= pkf_pkg::sadd(ONE_C, pkf_pkg::neg_sat(k0_reg));
                    cb_reg <= pkf_pkg::neg_sat(k1_reg);
                end
                pkf_pkg::M_T:    tt_reg <= pkf_pkg::sadd(ar_res, car_w);
                pkf_pkg::M_H0:   h0_reg <= ar_res;
                pkf_pkg::M_H1:   h1_reg <= ar_res;
                pkf_pkg::M_AP:   p1_reg <= ar_res;
                pkf_pkg::M_APA:  p1_reg <= ar_res;
                pkf_pkg::M_TB:   p1_reg <= ar_res;
                pkf_pkg::M_BP:   p1_reg <= pkf_pkg::sadd(p1_reg, pkf_pkg::sadd(ar_res, crr_w));
                pkf_pkg::M_TA:   p1_reg <= ar_res;
                pkf_pkg::T_B:
                begin
                    k0_reg <= (ga_w + gr_w) <<< 1;
                    k1_reg <= gr_w <<< 1;
                end
                pkf_pkg::T_X:
                    xw_reg <= pkf_pkg::sadd(pkf_pkg::sadd(ang_w, rat_w <<< 1), ar_res);
                pkf_pkg::T_P:
                begin
                    den_reg <= pkf_pkg::sadd(pkf_pkg::sadd(caa_w, car_w <<< 2), crr_w <<< 2);
                    tt_reg  <= pkf_pkg::sadd(car_w, crr_w <<< 1);
                end
                pkf_pkg::T_S0:   h0_reg <= ar_res;
                pkf_pkg::T_S1:   h1_reg <= ar_res;
                default: begin end
            endcase
        end
    end

`ifndef SYNTHESIS
    // the arithmetic unit only finishes operations the sequencer started
    a_done_requested: assert property (@(posedge clk) disable iff (!rst_n)
        ar_done |-> run_reg)
        else $error("arith done without a request");

    // a delivered result with nothing new to load leaves the register empty
    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !load_out |=> !result.valid)
        else $error("result valid held after transfer");

    // initialization clears the rate and the cross covariance
    a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && sample.mode == pkf_pkg::MODE_INIT |=> rat_reg == '0 && car_reg == '0)
        else $error("init left rate or cross term set");

    // a noise write lands in the register
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready && cfg.index == pkf_pkg::REG_MEAS_NOISE
        |=> r_reg == $past(cfg.data[COV_WIDTH-1:0]))
        else $error("measurement noise write lost");
`endif

endmodule
